[rtl/gsdm_pkg.sv]
package gsdm_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_DEADZONE_MIN      = 2'd0;
  localparam logic [1:0] REG_DEADZONE_MAX      = 2'd1;
  localparam logic [1:0] REG_TRIGGER_THRESHOLD = 2'd2;
  localparam logic [1:0] REG_PAD_ENABLE        = 2'd3;

  // configuration reset values
  localparam logic [14:0] DEADZONE_MIN_RST      = 15'd7864;
  localparam logic [14:0] DEADZONE_MAX_RST      = 15'd31784;
  localparam logic [7:0]  TRIGGER_THRESHOLD_RST = 8'd0;
  localparam logic        PAD_ENABLE_RST        = 1'b1;

  // strength levels in q1.15: 0.95 and 0.05 of full scale
  localparam logic [15:0] STRENGTH_ONE  = 16'h8000;
  localparam logic [15:0] STRENGTH_HIGH = 16'd31129;
  localparam logic [15:0] STRENGTH_LOW  = 16'd1638;
  localparam logic [15:0] AXIS_POS_MAX  = 16'h7fff;

  // virtual button bit positions
  localparam int BIT_RT       = 16;
  localparam int BIT_LT       = 17;
  localparam int BIT_RS_HIGH  = 18;
  localparam int BIT_LS_HIGH  = 19;
  localparam int BIT_RS_LOW   = 20;
  localparam int BIT_LS_LOW   = 21;
  localparam int BIT_LDIR     = 22;
  localparam int BIT_RDIR     = 26;

  // pipeline stage map
  localparam int RT_STEPS  = 24;  // one root bit per stage
  localparam int DIV_STEPS = 15;  // one quotient bit per stage
  localparam int ST_IN     = 0;
  localparam int ST_SQR    = 1;
  localparam int ST_SUM    = 2;
  localparam int ST_RT0    = 3;
  localparam int ST_SDV    = ST_RT0 + RT_STEPS;
  localparam int ST_SD0    = ST_SDV + 1;
  localparam int ST_SFN    = ST_SD0 + DIV_STEPS;
  localparam int ST_MUL    = ST_SFN + 1;
  localparam int ST_ADV    = ST_MUL + 1;
  localparam int ST_AD0    = ST_ADV + 1;
  localparam int ST_OUT    = ST_AD0 + DIV_STEPS;
  localparam int DEPTH     = ST_OUT + 1;

  // one sample in flight; axes 0..3 are left x, left y, right x, right y
  typedef struct packed {
    logic             zero;
    logic [15:0]      buttons;
    logic [7:0]       lt;
    logic [7:0]       rt;
    logic [3:0][15:0] ax;
    logic [3:0][31:0] sqa;
    logic [1:0][31:0] sq;
    logic [1:0][25:0] rem;
    logic [1:0][23:0] root;
    logic [1:0]       szero;
    logic [1:0]       ssat;
    logic [1:0][30:0] srem;
    logic [1:0][14:0] sqq;
    logic [1:0][15:0] s;
    logic [3:0][30:0] prod;
    logic [3:0]       asat;
    logic [3:0][38:0] arem;
    logic [3:0][14:0] aq;
    logic [29:0]      obits;
    logic [3:0][15:0] oax;
  } item_t;

  // magnitude of a two's complement axis, most negative reads 32768
  function automatic logic [15:0] abs16(input logic [15:0] a);
    abs16 = a[15] ? 16'(-a) : a;
  endfunction

endpackage

[rtl/gamepad_stick_deadzone_mapper.sv]
// Conditions raw gamepad samples: trigger threshold, per-axis minimum deadzone, stick length
// by integer square root, strength against the maximum deadzone and the scaled direction,
// plus virtual buttons. The datapath is a 62-stage pipeline: one sample is taken every clock
// unless the output side stalls. The depth is set by the bit-per-stage square root
// (24 stages) and the two bit-per-stage restoring dividers (15 stages each). A stall on the
// output side freezes the whole pipeline, so s_axis_tready follows m_axis_tready whenever
// the last stage holds a result. Configuration is written through cfg_we/cfg_index/cfg_data
// and must only change while no sample is in flight.
module gamepad_stick_deadzone_mapper (
  input  logic         clk,
  input  logic         rst,
  // configuration write port
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [14:0]  cfg_data,
  // input samples
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,  // raw_buttons, raw_left_trigger, raw_right_trigger,
                                      // raw_left_x, raw_left_y, raw_right_x, raw_right_y
  input  logic         s_axis_tuser,  // connected
  // conditioned pad state
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata   // button_bits, left_trigger, right_trigger, left_x,
                                      // left_y, right_x, right_y, left_strength,
                                      // right_strength, zero fill
);

  localparam int DEPTH = gsdm_pkg::DEPTH;

  logic [14:0] deadzone_min;
  logic [14:0] deadzone_max;
  logic [7:0]  trigger_threshold;
  logic        pad_enable;

  logic [DEPTH-1:0] vld;
  logic             adv;
  gsdm_pkg::item_t  pipe [DEPTH];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone_min      <= gsdm_pkg::DEADZONE_MIN_RST;
      deadzone_max      <= gsdm_pkg::DEADZONE_MAX_RST;
      trigger_threshold <= gsdm_pkg::TRIGGER_THRESHOLD_RST;
      pad_enable        <= gsdm_pkg::PAD_ENABLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gsdm_pkg::REG_DEADZONE_MIN:      deadzone_min      <= cfg_data;
        gsdm_pkg::REG_DEADZONE_MAX:      deadzone_max      <= cfg_data;
        gsdm_pkg::REG_TRIGGER_THRESHOLD: trigger_threshold <= cfg_data[7:0];
        gsdm_pkg::REG_PAD_ENABLE:        pad_enable        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline advances unless the last stage holds an untaken transaction
  assign adv           = !vld[DEPTH-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], s_axis_tvalid};
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_stage
    gsdm_pkg::item_t d;

    if (g == gsdm_pkg::ST_IN) begin : g_in
      // triggers, axis deadzone and the zero-output flag
      always_comb begin
        logic [15:0] a;
        d         = '0;
        d.zero    = !s_axis_tuser || !pad_enable;
        d.buttons = s_axis_tdata[15:0];
        d.lt      = (s_axis_tdata[23:16] <= trigger_threshold) ? 8'd0 : s_axis_tdata[23:16];
        d.rt      = (s_axis_tdata[31:24] <= trigger_threshold) ? 8'd0 : s_axis_tdata[31:24];
        for (int i = 0; i < 4; i++) begin
          a       = s_axis_tdata[32 + 16*i +: 16];
          d.ax[i] = (gsdm_pkg::abs16(a) < {1'b0, deadzone_min}) ? 16'd0 : a;
        end
      end
    end else if (g == gsdm_pkg::ST_SQR) begin : g_sqr
      // square of each axis magnitude
      always_comb begin
        logic [15:0] m;
        d = pipe[g-1];
        for (int i = 0; i < 4; i++) begin
          m        = gsdm_pkg::abs16(d.ax[i]);
          d.sqa[i] = m * m;
        end
      end
    end else if (g == gsdm_pkg::ST_SUM) begin : g_sum
      // squared stick length
      always_comb begin
        d = pipe[g-1];
        for (int j = 0; j < 2; j++) begin
          d.sq[j]   = d.sqa[2*j] + d.sqa[2*j+1];
          d.rem[j]  = '0;
          d.root[j] = '0;
        end
      end
    end else if (g >= gsdm_pkg::ST_RT0 && g < gsdm_pkg::ST_SDV) begin : g_root
      // one root bit: length in q.8 is the root of the squared length times 65536
      localparam int P = gsdm_pkg::RT_STEPS - 1 - (g - gsdm_pkg::ST_RT0);
      always_comb begin
        logic [47:0] v;
        logic [27:0] cur;
        logic [27:0] trial;
        d = pipe[g-1];
        for (int j = 0; j < 2; j++) begin
          v     = {d.sq[j], 16'b0};
          cur   = {d.rem[j], v[2*P+1 -: 2]};
          trial = {2'b0, d.root[j], 2'b01};
          if (cur >= trial) begin
            d.rem[j]  = 26'(cur - trial);
            d.root[j] = {d.root[j][22:0], 1'b1};
          end else begin
            d.rem[j]  = cur[25:0];
            d.root[j] = {d.root[j][22:0], 1'b0};
          end
        end
      end
    end else if (g == gsdm_pkg::ST_SDV) begin : g_sdv
      // strength dividend and full-strength detection
      always_comb begin
        d = pipe[g-1];
        for (int j = 0; j < 2; j++) begin
          d.srem[j]  = {d.root[j], 7'b0};
          d.szero[j] = (d.root[j] == 24'd0);
          d.ssat[j]  = ({d.root[j], 7'b0} >= {1'b0, deadzone_max, 15'b0});
          d.sqq[j]   = '0;
        end
      end
    end else if (g >= gsdm_pkg::ST_SD0 && g < gsdm_pkg::ST_SFN) begin : g_sdiv
      // one strength quotient bit
      localparam int BP = gsdm_pkg::DIV_STEPS - 1 - (g - gsdm_pkg::ST_SD0);
      always_comb begin
        logic [30:0] dv;
        d  = pipe[g-1];
        dv = {16'b0, deadzone_max} << BP;
        for (int j = 0; j < 2; j++) begin
          if (!d.ssat[j] && d.srem[j] >= dv) begin
            d.srem[j]    = d.srem[j] - dv;
            d.sqq[j][BP] = 1'b1;
          end
        end
      end
    end else if (g == gsdm_pkg::ST_SFN) begin : g_sfn
      // strength, capped at full scale
      always_comb begin
        d = pipe[g-1];
        for (int j = 0; j < 2; j++) begin
          if (d.szero[j]) begin
            d.s[j] = '0;
          end else if (d.ssat[j]) begin
            d.s[j] = gsdm_pkg::STRENGTH_ONE;
          end else begin
            d.s[j] = {1'b0, d.sqq[j]};
          end
        end
      end
    end else if (g == gsdm_pkg::ST_MUL) begin : g_mul
      // axis magnitude times strength
      always_comb begin
        logic [31:0] p;
        d = pipe[g-1];
        for (int i = 0; i < 4; i++) begin
          p         = gsdm_pkg::abs16(d.ax[i]) * d.s[i/2];
          d.prod[i] = p[30:0];
        end
      end
    end else if (g == gsdm_pkg::ST_ADV) begin : g_adv
      // rounded axis dividend and saturation detection
      always_comb begin
        logic [38:0] n;
        d = pipe[g-1];
        for (int i = 0; i < 4; i++) begin
          n         = {d.prod[i], 8'b0} + {16'b0, d.root[i/2][23:1]};
          d.arem[i] = n;
          d.asat[i] = (n >= {d.root[i/2], 15'b0});
          d.aq[i]   = '0;
        end
      end
    end else if (g >= gsdm_pkg::ST_AD0 && g < gsdm_pkg::ST_OUT) begin : g_adiv
      // one axis quotient bit
      localparam int BP = gsdm_pkg::DIV_STEPS - 1 - (g - gsdm_pkg::ST_AD0);
      always_comb begin
        logic [38:0] dv;
        d = pipe[g-1];
        for (int i = 0; i < 4; i++) begin
          dv = {15'b0, d.root[i/2]} << BP;
          if (!d.asat[i] && d.arem[i] >= dv) begin
            d.arem[i]    = d.arem[i] - dv;
            d.aq[i][BP] = 1'b1;
          end
        end
      end
    end else begin : g_out
      // signed saturated axes, virtual buttons and zero forcing
      always_comb begin
        logic [15:0] q;
        logic        hot;
        d = pipe[g-1];
        d.obits = {14'b0, d.buttons};
        d.obits[gsdm_pkg::BIT_RT] = (d.rt != 8'd0);
        d.obits[gsdm_pkg::BIT_LT] = (d.lt != 8'd0);
        d.obits[gsdm_pkg::BIT_RS_HIGH] = (d.s[1] > gsdm_pkg::STRENGTH_HIGH);
        d.obits[gsdm_pkg::BIT_LS_HIGH] = (d.s[0] > gsdm_pkg::STRENGTH_HIGH);
        d.obits[gsdm_pkg::BIT_RS_LOW]  = (d.s[1] > gsdm_pkg::STRENGTH_LOW);
        d.obits[gsdm_pkg::BIT_LS_LOW]  = (d.s[0] > gsdm_pkg::STRENGTH_LOW);
        for (int j = 0; j < 2; j++) begin
          hot = (d.s[j] > gsdm_pkg::STRENGTH_LOW);
          // right, up, left, down
          d.obits[gsdm_pkg::BIT_LDIR + 4*j + 0] = hot && !d.ax[2*j][15] && d.ax[2*j] != 16'd0;
          d.obits[gsdm_pkg::BIT_LDIR + 4*j + 1] =
            hot && !d.ax[2*j+1][15] && d.ax[2*j+1] != 16'd0;
          d.obits[gsdm_pkg::BIT_LDIR + 4*j + 2] = hot && d.ax[2*j][15];
          d.obits[gsdm_pkg::BIT_LDIR + 4*j + 3] = hot && d.ax[2*j+1][15];
        end
        for (int i = 0; i < 4; i++) begin
          q = d.asat[i] ? gsdm_pkg::STRENGTH_ONE : {1'b0, d.aq[i]};
          if (d.ax[i] == 16'd0) begin
            d.oax[i] = '0;
          end else if (!d.ax[i][15]) begin
            d.oax[i] = d.asat[i] ? gsdm_pkg::AXIS_POS_MAX : q;
          end else begin
            d.oax[i] = 16'(-q);
          end
        end
        if (d.zero) begin
          d.obits = '0;
          d.lt    = '0;
          d.rt    = '0;
          d.oax   = '0;
          d.s     = '0;
        end
      end
    end

    // stage register, payload only
    always_ff @(posedge clk) begin
      if (adv) begin
        pipe[g] <= d;
      end
    end
  end

  // result packing
  assign m_axis_tdata = {2'b0,
                         pipe[DEPTH-1].s[1],
                         pipe[DEPTH-1].s[0],
                         pipe[DEPTH-1].oax[3],
                         pipe[DEPTH-1].oax[2],
                         pipe[DEPTH-1].oax[1],
                         pipe[DEPTH-1].oax[0],
                         pipe[DEPTH-1].rt,
                         pipe[DEPTH-1].lt,
                         pipe[DEPTH-1].obits};

endmodule
